// File: rtl/nharp_pkg.sv
// nharp_pkg: sizes, codes and command type of the next hop forwarder
// used by every file of the block but nharp_if; depends on nothing
`default_nettype none
package nharp_pkg;
   localparam int ROUTE_COUNT   = 8;
   localparam int CACHE_COUNT   = 16;
   localparam int PENDING_COUNT = 32;
   localparam int BUFFER_COUNT  = 512;
   localparam int QUEUE_DEPTH   = 2;

   localparam int ROUTE_IDX_W = (ROUTE_COUNT > 1) ? $clog2(ROUTE_COUNT) : 1;
   localparam int CACHE_IDX_W = (CACHE_COUNT > 1) ? $clog2(CACHE_COUNT) : 1;
   localparam int RANK_W      = (PENDING_COUNT > 1) ? $clog2(PENDING_COUNT) : 1;
   localparam int CNT_W       = $clog2(PENDING_COUNT + 1);
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ACT_PACKET   = 2'd0;
   localparam logic [1:0] ACT_RESPONSE = 2'd1;
   localparam logic [1:0] ACT_ROUTE_WR = 2'd2;
   localparam logic [1:0] ACT_CACHE_WR = 2'd3;

   localparam logic [1:0] KIND_TX   = 2'd0;
   localparam logic [1:0] KIND_FREE = 2'd1;
   localparam logic [1:0] KIND_REQ  = 2'd2;

   localparam logic [1:0] CMD_TX   = 2'd0;
   localparam logic [1:0] CMD_FREE = 2'd1;
   localparam logic [1:0] CMD_MISS = 2'd2;
   localparam logic [1:0] CMD_REL  = 2'd3;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

   typedef struct packed {
      logic [1:0]  code;
      logic [31:0] ip;
      logic [8:0]  buffer;
      logic [7:0]  ttl;
      logic [47:0] mac;
      logic        flag;
   } cmd_type;
endpackage
`default_nettype wire

// File: rtl/nharp_if.sv
// nharp request and response channel interfaces
// depends on nothing
`default_nettype none
interface nharp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] ip_addr;
   logic [31:0] route_mask;
   logic [31:0] route_hop;
   logic [3:0]  slot;
   logic [47:0] hw_addr;
   logic [7:0]  hop_limit;
   logic [15:0] ether_kind;
   logic [8:0]  buffer_id;
   logic        reply_ok;
   logic        request_room;
   logic        entry_valid;
   modport source (output valid, action, ip_addr, route_mask, route_hop, slot, hw_addr,
                   hop_limit, ether_kind, buffer_id, reply_ok, request_room, entry_valid,
                   input ready);
   modport sink (input valid, action, ip_addr, route_mask, route_hop, slot, hw_addr,
                 hop_limit, ether_kind, buffer_id, reply_ok, request_room, entry_valid,
                 output ready);
endinterface

interface nharp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [8:0]  out_buffer;
   logic [47:0] dest_mac;
   logic [7:0]  new_ttl;
   logic [31:0] query_ip;
   logic        last;
   modport source (output valid, kind, out_buffer, dest_mac, new_ttl, query_ip, last,
                   input ready);
   modport sink (input valid, kind, out_buffer, dest_mac, new_ttl, query_ip, last,
                 output ready);
endinterface
`default_nettype wire

// File: rtl/nharp_front.sv
// nharp_front: accepts requests, owns route and cache tables, classifies packets
// depends on nharp_pkg and nharp_if
`default_nettype none
module nharp_front
   import nharp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   nharp_req_if.sink  req_if,
   output cmd_type    push_data,
   output logic       push_valid,
   input  wire logic  push_ready
);
   logic [31:0] route_mask_ff [ROUTE_COUNT];
   logic [31:0] route_net_ff [ROUTE_COUNT];
   logic [31:0] route_hop_ff [ROUTE_COUNT];
   logic        cache_valid_ff [CACHE_COUNT];
   logic [31:0] cache_ip_ff [CACHE_COUNT];
   logic [47:0] cache_mac_ff [CACHE_COUNT];

   logic        stage_valid_ff, stage_valid_in;
   logic        stage_rel_ff, stage_drop_ff, stage_flag_ff;
   logic [31:0] stage_ip_ff;
   logic [8:0]  stage_buf_ff;
   logic [7:0]  stage_ttl_ff;
   logic [47:0] stage_hw_ff;

   logic        accept;
   logic [31:0] hop;
   logic        hit;
   logic [47:0] hit_mac;

   assign req_if.ready = !stage_valid_ff || push_ready;
   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      hop = req_if.ip_addr;
      for (int i = ROUTE_COUNT - 1; i >= 0; i--) begin
         if (route_mask_ff[i] != 32'd0 &&
             (req_if.ip_addr & route_mask_ff[i]) == (route_net_ff[i] & route_mask_ff[i]))
            hop = route_hop_ff[i];
      end
   end

   always_comb begin
      hit = 1'b0;
      hit_mac = 48'd0;
      for (int i = CACHE_COUNT - 1; i >= 0; i--) begin
         if (cache_valid_ff[i] && cache_ip_ff[i] == stage_ip_ff) begin
            hit = 1'b1;
            hit_mac = cache_mac_ff[i];
         end
      end
   end

   always_comb begin
      push_valid = stage_valid_ff;
      push_data.ip = stage_ip_ff;
      push_data.buffer = stage_buf_ff;
      push_data.ttl = stage_ttl_ff;
      push_data.mac = stage_hw_ff;
      push_data.flag = stage_flag_ff;
      if (stage_rel_ff) begin
         push_data.code = CMD_REL;
      end else if (stage_drop_ff) begin
         push_data.code = CMD_FREE;
      end else if (hit) begin
         push_data.code = CMD_TX;
         push_data.mac = hit_mac;
      end else begin
         push_data.code = CMD_MISS;
      end
   end

   always_comb begin
      if (accept)
         stage_valid_in = (req_if.action == ACT_PACKET) || (req_if.action == ACT_RESPONSE);
      else
         stage_valid_in = stage_valid_ff && !push_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         for (int i = 0; i < ROUTE_COUNT; i++)
            route_mask_ff[i] <= 32'd0;
         for (int i = 0; i < CACHE_COUNT; i++)
            cache_valid_ff[i] <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (accept && req_if.action == ACT_ROUTE_WR &&
             {28'd0, req_if.slot} < ROUTE_COUNT) begin
            route_mask_ff[req_if.slot[ROUTE_IDX_W-1:0]] <= req_if.route_mask;
            route_net_ff[req_if.slot[ROUTE_IDX_W-1:0]] <= req_if.ip_addr;
            route_hop_ff[req_if.slot[ROUTE_IDX_W-1:0]] <= req_if.route_hop;
         end
         if (accept && req_if.action == ACT_CACHE_WR &&
             {28'd0, req_if.slot} < CACHE_COUNT) begin
            cache_valid_ff[req_if.slot[CACHE_IDX_W-1:0]] <= req_if.entry_valid;
            cache_ip_ff[req_if.slot[CACHE_IDX_W-1:0]] <= req_if.ip_addr;
            cache_mac_ff[req_if.slot[CACHE_IDX_W-1:0]] <= req_if.hw_addr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_rel_ff <= (req_if.action == ACT_RESPONSE);
         stage_drop_ff <= !(req_if.hop_limit > 8'd1 && req_if.ether_kind == ETHERTYPE_IPV4);
         stage_ip_ff <= (req_if.action == ACT_RESPONSE) ? req_if.ip_addr : hop;
         stage_buf_ff <= req_if.buffer_id;
         stage_ttl_ff <= req_if.hop_limit - 8'd1;
         stage_hw_ff <= req_if.hw_addr;
         stage_flag_ff <= (req_if.action == ACT_RESPONSE) ? req_if.reply_ok
                                                          : req_if.request_room;
      end
   end
endmodule
`default_nettype wire

// File: rtl/nharp_queue.sv
// nharp_queue: short command queue between front and back
// depends on nharp_pkg
`default_nettype none
module nharp_queue
   import nharp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type push_data,
   input  wire logic    push_valid,
   output logic         push_ready,
   output cmd_type      pop_data,
   output logic         pop_valid,
   input  wire logic    pop_ready
);
   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               do_push, do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_ff <= count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_data;
   end
endmodule
`default_nettype wire

// File: rtl/nharp_back.sv
// nharp_back: pending store, arp request raising, ordered release, response register
// depends on nharp_pkg and nharp_if
`default_nettype none
module nharp_back
   import nharp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type pop_data,
   input  wire logic    pop_valid,
   output logic         pop_ready,
   nharp_rsp_if.source  rsp_if
);
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                     pend_valid_ff [PENDING_COUNT];
   logic [31:0]              pend_ip_ff [PENDING_COUNT];
   logic [8:0]               pend_buf_ff [PENDING_COUNT];
   logic [7:0]               pend_ttl_ff [PENDING_COUNT];
   logic [RANK_W-1:0]        pend_rank_ff [PENDING_COUNT];
   logic [CNT_W-1:0]         count_ff;

   logic                     state_ff, state_in;
   cmd_type                  cur_ff, cur_in;
   logic [PENDING_COUNT-1:0] match_ff, match_in, match_now, sel, sel_next, free_vec;
   logic [RANK_W-1:0]        rank_ff, rank_in;

   logic                     rsp_valid_ff;
   logic [1:0]               kind_ff, kind_in;
   logic [8:0]               buf_ff, buf_in;
   logic [47:0]              mac_ff, mac_in;
   logic [7:0]               ttl_ff, ttl_in;
   logic [31:0]              qip_ff, qip_in;
   logic                     last_ff, last_in;

   logic                     out_free, emit, park, clear;
   logic [RANK_W-1:0]        park_rank;
   logic [RANK_W-1:0]        park_idx;
   logic [CNT_W-1:0]         group;
   logic [8:0]               sel_buf;
   logic [7:0]               sel_ttl;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.kind = kind_ff;
   assign rsp_if.out_buffer = buf_ff;
   assign rsp_if.dest_mac = mac_ff;
   assign rsp_if.new_ttl = ttl_ff;
   assign rsp_if.query_ip = qip_ff;
   assign rsp_if.last = last_ff;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      group = '0;
      park_idx = '0;
      sel_buf = '0;
      sel_ttl = '0;
      for (int i = 0; i < PENDING_COUNT; i++) begin
         match_now[i] = pend_valid_ff[i] && pend_ip_ff[i] == pop_data.ip;
         sel[i] = match_ff[i] && pend_rank_ff[i] == rank_ff;
         sel_next[i] = match_ff[i] && pend_rank_ff[i] == rank_ff + 1'b1;
         free_vec[i] = !pend_valid_ff[i];
         group = group + CNT_W'(match_ff[i]);
         if (sel[i]) begin
            sel_buf = sel_buf | pend_buf_ff[i];
            sel_ttl = sel_ttl | pend_ttl_ff[i];
         end
      end
      for (int i = PENDING_COUNT - 1; i >= 0; i--) begin
         if (free_vec[i])
            park_idx = RANK_W'(i);
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      match_in = match_ff;
      rank_in = rank_ff;
      pop_ready = 1'b0;
      emit = 1'b0;
      park = 1'b0;
      park_rank = '0;
      clear = 1'b0;
      kind_in = KIND_FREE;
      buf_in = '0;
      mac_in = '0;
      ttl_in = '0;
      qip_in = '0;
      last_in = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               if (pop_data.code == CMD_TX || pop_data.code == CMD_FREE) begin
                  if (out_free) begin
                     pop_ready = 1'b1;
                     emit = 1'b1;
                     buf_in = pop_data.buffer;
                     if (pop_data.code == CMD_TX) begin
                        kind_in = KIND_TX;
                        mac_in = pop_data.mac;
                        ttl_in = pop_data.ttl;
                     end
                  end
               end else begin
                  pop_ready = 1'b1;
                  cur_in = pop_data;
                  match_in = match_now;
                  rank_in = '0;
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            if (cur_ff.code == CMD_MISS) begin
               if (out_free) begin
                  state_in = ST_IDLE;
                  if (count_ff == CNT_W'(PENDING_COUNT)) begin
                     emit = 1'b1;
                     buf_in = cur_ff.buffer;
                  end else if (group != '0) begin
                     park = 1'b1;
                     park_rank = group[RANK_W-1:0];
                  end else if (!cur_ff.flag) begin
                     emit = 1'b1;
                     buf_in = cur_ff.buffer;
                  end else begin
                     park = 1'b1;
                     emit = 1'b1;
                     kind_in = KIND_REQ;
                     qip_in = cur_ff.ip;
                  end
               end
            end else if (sel == '0) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               emit = 1'b1;
               clear = 1'b1;
               buf_in = sel_buf;
               if (cur_ff.flag) begin
                  kind_in = KIND_TX;
                  mac_in = cur_ff.mac;
                  ttl_in = sel_ttl;
               end
               last_in = sel_next == '0;
               match_in = match_ff & ~sel;
               rank_in = rank_ff + 1'b1;
               if (sel_next == '0)
                  state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
         for (int i = 0; i < PENDING_COUNT; i++)
            pend_valid_ff[i] <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit)
            rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready)
            rsp_valid_ff <= 1'b0;
         count_ff <= count_ff + CNT_W'(park) - CNT_W'(clear);
         for (int i = 0; i < PENDING_COUNT; i++) begin
            if (clear && sel[i])
               pend_valid_ff[i] <= 1'b0;
         end
         if (park)
            pend_valid_ff[park_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      match_ff <= match_in;
      rank_ff <= rank_in;
      if (park) begin
         pend_ip_ff[park_idx] <= cur_ff.ip;
         pend_buf_ff[park_idx] <= cur_ff.buffer;
         pend_ttl_ff[park_idx] <= cur_ff.ttl;
         pend_rank_ff[park_idx] <= park_rank;
      end
      if (emit) begin
         kind_ff <= kind_in;
         buf_ff <= buf_in;
         mac_ff <= mac_in;
         ttl_ff <= ttl_in;
         qip_ff <= qip_in;
         last_ff <= last_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/ip_next_hop_arp_wait_forwarder.sv
// ip_next_hop_arp_wait_forwarder: ipv4 next hop forwarder with arp wait store
// a request is taken every cycle while the two-entry command queue has room
// a packet or drop result leaves through the response register; an arp response releases
// one waiting buffer per cycle from the pending store while that register is free, set
// by the rank search; a cache miss passes queue pop, then group count in the back end
// synchronous reset empties routes, cache, pending store and queue at once
`default_nettype none
module ip_next_hop_arp_wait_forwarder
   import nharp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   nharp_req_if.sink        req_if,
   nharp_rsp_if.source      rsp_if,
   input  wire logic        csr_wr_en,
   input  wire logic [47:0] csr_wr_data
);
   logic [47:0] own_mac_ff;
   cmd_type     push_data, pop_data;
   logic        push_valid, push_ready, pop_valid, pop_ready;

   always_ff @(posedge clock) begin
      if (reset)
         own_mac_ff <= 48'd0;
      else if (csr_wr_en)
         own_mac_ff <= csr_wr_data;
   end

   nharp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   nharp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   nharp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_data  (pop_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );
endmodule
`default_nettype wire

// File: verif/tb_ip_next_hop_arp_wait_forwarder.sv
// testbench for ip_next_hop_arp_wait_forwarder: queue-fed driver, clocked monitor,
// in-bench forwarder predictor compared field by field against every response
// depends on nharp_pkg, nharp_if and the block itself
`default_nettype none
module tb_ip_next_hop_arp_wait_forwarder;
   import nharp_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_GAP   = 16;

   typedef struct {
      logic [1:0]  action;
      logic [31:0] ip_addr;
      logic [31:0] route_mask;
      logic [31:0] route_hop;
      logic [3:0]  slot;
      logic [47:0] hw_addr;
      logic [7:0]  hop_limit;
      logic [15:0] ether_kind;
      logic [8:0]  buffer_id;
      logic        reply_ok;
      logic        request_room;
      logic        entry_valid;
   } fwd_req_t;

   typedef struct {
      logic [1:0]  kind;
      logic [8:0]  out_buffer;
      logic [47:0] dest_mac;
      logic [7:0]  new_ttl;
      logic [31:0] query_ip;
      logic        last;
   } fwd_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_wr_en;
   logic [47:0] csr_wr_data;

   nharp_req_if req_bus();
   nharp_rsp_if rsp_bus();

   ip_next_hop_arp_wait_forwarder dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [31:0] rt_mask [ROUTE_COUNT];
   logic [31:0] rt_net  [ROUTE_COUNT];
   logic [31:0] rt_hop  [ROUTE_COUNT];
   logic        arp_ok  [CACHE_COUNT];
   logic [31:0] arp_ip  [CACHE_COUNT];
   logic [47:0] arp_mac [CACHE_COUNT];
   logic        wait_ok   [PENDING_COUNT];
   logic [31:0] wait_ip   [PENDING_COUNT];
   logic [8:0]  wait_buf  [PENDING_COUNT];
   logic [7:0]  wait_ttl  [PENDING_COUNT];
   int          wait_rank [PENDING_COUNT];
   int          wait_count;
   logic [47:0] own_mac_shadow;

   fwd_req_t request_q[$];
   fwd_rsp_t forward_q[$];
   logic [31:0] ip_pool[8];

   int send_idle = 6;
   int recv_idle = 47;
   int fail_count = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int quiet = 0;

   function automatic fwd_rsp_t mk_rsp(logic [1:0] k, logic [8:0] b, logic [47:0] m,
                                        logic [7:0] t, logic [31:0] q);
      fwd_rsp_t r;
      r.kind = k; r.out_buffer = b; r.dest_mac = m; r.new_ttl = t; r.query_ip = q;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic void park_buffer(logic [31:0] ip, logic [8:0] b, logic [7:0] t, int rk);
      for (int i = 0; i < PENDING_COUNT; i++) begin
         if (!wait_ok[i]) begin
            wait_ok[i] = 1'b1; wait_ip[i] = ip; wait_buf[i] = b;
            wait_ttl[i] = t; wait_rank[i] = rk;
            wait_count++;
            return;
         end
      end
   endfunction

   function automatic void forward_predict(fwd_req_t q);
      fwd_rsp_t outs[$];
      logic [31:0] hop;
      logic [7:0]  nttl;
      int group;
      bit hit;
      fwd_rsp_t tail;
      case (q.action)
         ACT_PACKET: begin
            if (q.hop_limit > 8'd1 && q.ether_kind == ETHERTYPE_IPV4) begin
               nttl = q.hop_limit - 8'd1;
               hop = q.ip_addr;
               for (int i = ROUTE_COUNT - 1; i >= 0; i--)
                  if (rt_mask[i] != 0 && (q.ip_addr & rt_mask[i]) == (rt_net[i] & rt_mask[i]))
                     hop = rt_hop[i];
               hit = 0;
               for (int i = 0; i < CACHE_COUNT; i++) begin
                  if (!hit && arp_ok[i] && arp_ip[i] == hop) begin
                     outs.push_back(mk_rsp(KIND_TX, q.buffer_id, arp_mac[i], nttl, '0));
                     hit = 1;
                  end
               end
               if (!hit) begin
                  if (wait_count >= PENDING_COUNT) begin
                     outs.push_back(mk_rsp(KIND_FREE, q.buffer_id, '0, '0, '0));
                  end else begin
                     group = 0;
                     for (int i = 0; i < PENDING_COUNT; i++)
                        if (wait_ok[i] && wait_ip[i] == hop) group++;
                     if (group > 0) begin
                        park_buffer(hop, q.buffer_id, nttl, group);
                     end else if (!q.request_room) begin
                        outs.push_back(mk_rsp(KIND_FREE, q.buffer_id, '0, '0, '0));
                     end else begin
                        park_buffer(hop, q.buffer_id, nttl, 0);
                        outs.push_back(mk_rsp(KIND_REQ, '0, '0, '0, hop));
                     end
                  end
               end
            end else begin
               outs.push_back(mk_rsp(KIND_FREE, q.buffer_id, '0, '0, '0));
            end
         end
         ACT_RESPONSE: begin
            for (int r = 0; r < PENDING_COUNT; r++)
               for (int i = 0; i < PENDING_COUNT; i++)
                  if (wait_ok[i] && wait_ip[i] == q.ip_addr && wait_rank[i] == r) begin
                     if (q.reply_ok)
                        outs.push_back(mk_rsp(KIND_TX, wait_buf[i], q.hw_addr, wait_ttl[i],
                                              '0));
                     else
                        outs.push_back(mk_rsp(KIND_FREE, wait_buf[i], '0, '0, '0));
                     wait_ok[i] = 1'b0;
                     if (wait_count > 0) wait_count--;
                  end
         end
         ACT_ROUTE_WR: begin
            if (q.slot < ROUTE_COUNT) begin
               rt_mask[q.slot] = q.route_mask;
               rt_net[q.slot] = q.ip_addr;
               rt_hop[q.slot] = q.route_hop;
            end
         end
         default: begin
            if (q.slot < CACHE_COUNT) begin
               arp_ok[q.slot] = q.entry_valid;
               arp_ip[q.slot] = q.ip_addr;
               arp_mac[q.slot] = q.hw_addr;
            end
         end
      endcase
      if (outs.size() > 0) begin
         tail = outs[outs.size() - 1];
         tail.last = 1'b1;
         outs[outs.size() - 1] = tail;
      end
      foreach (outs[i]) forward_q.push_back(outs[i]);
   endfunction

   // driver
   initial begin
      req_bus.valid = 1'b0;
      req_bus.action = ACT_PACKET;
      req_bus.ip_addr = '0; req_bus.route_mask = '0; req_bus.route_hop = '0;
      req_bus.slot = '0; req_bus.hw_addr = '0; req_bus.hop_limit = '0;
      req_bus.ether_kind = '0; req_bus.buffer_id = '0; req_bus.reply_ok = 1'b0;
      req_bus.request_room = 1'b0; req_bus.entry_valid = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
   end

   always @(posedge clock) begin
      fwd_req_t cur;
      fwd_req_t nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            cur.action = req_bus.action; cur.ip_addr = req_bus.ip_addr;
            cur.route_mask = req_bus.route_mask; cur.route_hop = req_bus.route_hop;
            cur.slot = req_bus.slot; cur.hw_addr = req_bus.hw_addr;
            cur.hop_limit = req_bus.hop_limit; cur.ether_kind = req_bus.ether_kind;
            cur.buffer_id = req_bus.buffer_id; cur.reply_ok = req_bus.reply_ok;
            cur.request_room = req_bus.request_room; cur.entry_valid = req_bus.entry_valid;
            forward_predict(cur);
            requests_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (request_q.size() > 0 && $urandom_range(99) >= send_idle) begin
               nxt = request_q.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.action <= nxt.action; req_bus.ip_addr <= nxt.ip_addr;
               req_bus.route_mask <= nxt.route_mask; req_bus.route_hop <= nxt.route_hop;
               req_bus.slot <= nxt.slot; req_bus.hw_addr <= nxt.hw_addr;
               req_bus.hop_limit <= nxt.hop_limit; req_bus.ether_kind <= nxt.ether_kind;
               req_bus.buffer_id <= nxt.buffer_id; req_bus.reply_ok <= nxt.reply_ok;
               req_bus.request_room <= nxt.request_room;
               req_bus.entry_valid <= nxt.entry_valid;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      fwd_rsp_t want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            responses_seen++;
            if (forward_q.size() == 0) begin
               $error("unexpected response kind %0d buffer %0d", rsp_bus.kind,
                      rsp_bus.out_buffer);
               fail_count++;
            end else begin
               want = forward_q.pop_front();
               if (rsp_bus.kind !== want.kind) begin
                  $error("kind expected %0d actual %0d", want.kind, rsp_bus.kind);
                  fail_count++;
               end
               if (rsp_bus.out_buffer !== want.out_buffer) begin
                  $error("out_buffer expected %0d actual %0d", want.out_buffer,
                         rsp_bus.out_buffer);
                  fail_count++;
               end
               if (rsp_bus.dest_mac !== want.dest_mac) begin
                  $error("dest_mac expected %h actual %h", want.dest_mac, rsp_bus.dest_mac);
                  fail_count++;
               end
               if (rsp_bus.new_ttl !== want.new_ttl) begin
                  $error("new_ttl expected %0d actual %0d", want.new_ttl, rsp_bus.new_ttl);
                  fail_count++;
               end
               if (rsp_bus.query_ip !== want.query_ip) begin
                  $error("query_ip expected %h actual %h", want.query_ip, rsp_bus.query_ip);
                  fail_count++;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last expected %0d actual %0d", want.last, rsp_bus.last);
                  fail_count++;
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet <= 0;
         else
            quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("watchdog expired with %0d responses outstanding", forward_q.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic fwd_req_t rand_req();
      fwd_req_t q;
      q.action = 2'($urandom_range(3));
      q.ip_addr = ($urandom_range(3) != 0) ? ip_pool[$urandom_range(7)] : $urandom();
      q.route_mask = ($urandom_range(3) == 0) ? $urandom() : ~(32'hFFFF_FFFF >> $urandom_range(32));
      q.route_hop = ($urandom_range(3) != 0) ? ip_pool[$urandom_range(7)] : $urandom();
      q.slot = 4'($urandom_range(15));
      q.hw_addr = 48'({$urandom(), $urandom()});
      q.hop_limit = 8'(($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(255));
      q.ether_kind = ($urandom_range(9) == 0) ? 16'($urandom()) : ETHERTYPE_IPV4;
      q.buffer_id = 9'($urandom_range(511));
      q.reply_ok = $urandom_range(3) != 0;
      q.request_room = $urandom_range(7) != 0;
      q.entry_valid = $urandom_range(3) != 0;
      return q;
   endfunction

   function automatic fwd_req_t fixed_req(logic [1:0] act, logic [31:0] ip, logic [7:0] ttl,
                                          logic [15:0] ek, logic [8:0] b, logic room);
      fwd_req_t q;
      q = rand_req();
      q.action = act; q.ip_addr = ip; q.hop_limit = ttl; q.ether_kind = ek;
      q.buffer_id = b; q.request_room = room;
      return q;
   endfunction

   task automatic drain_all();
      while (request_q.size() > 0 || req_bus.valid || forward_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic csr_write(logic [47:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      own_mac_shadow = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(int count);
      fwd_req_t q;
      logic [31:0] far_ip;
      int made;
      made = 0;
      while (made < count) begin
         if ($urandom_range(39) == 0) begin
            // fill the wait store past capacity, then release the whole group
            far_ip = {8'hE0, 24'($urandom_range(24'hFFFFFF))};
            for (int k = 0; k < PENDING_COUNT + 2; k++)
               request_q.push_back(fixed_req(ACT_PACKET, far_ip, 8'($urandom_range(255, 2)),
                                             ETHERTYPE_IPV4, 9'($urandom_range(511)), 1'b1));
            q = rand_req();
            q.action = ACT_RESPONSE; q.ip_addr = far_ip;
            request_q.push_back(q);
            made += PENDING_COUNT + 3;
         end else begin
            q = rand_req();
            if ($urandom_range(1) == 0) q.action = ACT_PACKET;
            request_q.push_back(q);
            made++;
         end
      end
   endtask

   initial begin
      for (int i = 0; i < ROUTE_COUNT; i++) begin
         rt_mask[i] = '0; rt_net[i] = '0; rt_hop[i] = '0;
      end
      for (int i = 0; i < CACHE_COUNT; i++) begin
         arp_ok[i] = 1'b0; arp_ip[i] = '0; arp_mac[i] = '0;
      end
      for (int i = 0; i < PENDING_COUNT; i++) begin
         wait_ok[i] = 1'b0; wait_ip[i] = '0; wait_buf[i] = '0; wait_ttl[i] = '0;
         wait_rank[i] = 0;
      end
      wait_count = 0;
      own_mac_shadow = '0;
      foreach (ip_pool[i]) ip_pool[i] = $urandom();

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      csr_write(48'hFFFF_FFFF_FFFF);

      // directed
      begin
         fwd_req_t q;
         q = rand_req(); q.action = ACT_ROUTE_WR; q.slot = 4'd0; q.route_mask = 32'hFFFF_FFFF;
         q.ip_addr = ip_pool[0]; q.route_hop = ip_pool[1]; request_q.push_back(q);
         q = rand_req(); q.action = ACT_ROUTE_WR; q.slot = 4'd9; q.route_mask = 32'hFFFF_FFFF;
         q.ip_addr = ip_pool[2]; q.route_hop = ip_pool[4]; request_q.push_back(q);
         q = rand_req(); q.action = ACT_ROUTE_WR; q.slot = 4'd7; q.route_mask = 32'h0;
         q.ip_addr = ip_pool[3]; q.route_hop = ip_pool[4]; request_q.push_back(q);
         q = rand_req(); q.action = ACT_CACHE_WR; q.slot = 4'd15; q.entry_valid = 1'b1;
         q.ip_addr = ip_pool[1]; q.hw_addr = 48'hFFFF_FFFF_FFFF; request_q.push_back(q);
         q = rand_req(); q.action = ACT_CACHE_WR; q.slot = 4'd3; q.entry_valid = 1'b1;
         q.ip_addr = ip_pool[1]; q.hw_addr = 48'h0; request_q.push_back(q);
         request_q.push_back(fixed_req(ACT_PACKET, ip_pool[0], 8'd0, ETHERTYPE_IPV4, 9'd0, 1'b1));
         request_q.push_back(fixed_req(ACT_PACKET, ip_pool[0], 8'd1, ETHERTYPE_IPV4, 9'd511,
                                       1'b1));
         request_q.push_back(fixed_req(ACT_PACKET, ip_pool[0], 8'd255, 16'h86DD, 9'd5, 1'b1));
         request_q.push_back(fixed_req(ACT_PACKET, ip_pool[0], 8'd255, ETHERTYPE_IPV4, 9'd511,
                                       1'b1));
         request_q.push_back(fixed_req(ACT_PACKET, ip_pool[0], 8'd2, ETHERTYPE_IPV4, 9'd0, 1'b0));
         request_q.push_back(fixed_req(ACT_PACKET, ip_pool[2], 8'd9, ETHERTYPE_IPV4, 9'd7, 1'b0));
         request_q.push_back(fixed_req(ACT_PACKET, ip_pool[2], 8'd9, ETHERTYPE_IPV4, 9'd8, 1'b1));
         request_q.push_back(fixed_req(ACT_PACKET, ip_pool[2], 8'd200, ETHERTYPE_IPV4, 9'd9,
                                       1'b0));
         request_q.push_back(fixed_req(ACT_PACKET, ip_pool[3], 8'd2, ETHERTYPE_IPV4, 9'd10,
                                       1'b1));
         q = rand_req(); q.action = ACT_RESPONSE; q.ip_addr = ip_pool[5]; request_q.push_back(q);
         q = rand_req(); q.action = ACT_RESPONSE; q.ip_addr = ip_pool[2]; q.reply_ok = 1'b1;
         q.hw_addr = 48'hFFFF_FFFF_FFFF; request_q.push_back(q);
         q = rand_req(); q.action = ACT_RESPONSE; q.ip_addr = ip_pool[3]; q.reply_ok = 1'b0;
         request_q.push_back(q);
         q = rand_req(); q.action = ACT_CACHE_WR; q.slot = 4'd3; q.entry_valid = 1'b0;
         q.ip_addr = ip_pool[1]; request_q.push_back(q);
         request_q.push_back(fixed_req(ACT_PACKET, ip_pool[0], 8'd128, ETHERTYPE_IPV4, 9'd256,
                                       1'b1));
      end
      random_phase(110);
      drain_all();

      send_idle = 47;
      recv_idle = 6;
      csr_write(48'h0);
      random_phase(130);
      drain_all();

      send_idle = 0;
      recv_idle = 0;
      csr_write(48'({$urandom(), $urandom()}));
      random_phase(130);
      drain_all();

      $display("covered %0d requests and %0d checked responses over three stall profiles",
               requests_sent, responses_seen);
      $display("final own mac setting %h", own_mac_shadow);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
rtl/nharp_pkg.sv
rtl/nharp_if.sv
rtl/nharp_front.sv
rtl/nharp_queue.sv
rtl/nharp_back.sv
rtl/ip_next_hop_arp_wait_forwarder.sv
verif/tb_ip_next_hop_arp_wait_forwarder.sv
